@@ rtl/rpr_pkg.sv @@
`timescale 1ns / 1ps

package rpr_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_COLOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAINT_COLOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_CHANNEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAIR     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_PAIR    = 3'd7;

    // filter channel codes
    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    typedef enum logic [1:0] {
        MODE_REPLACE = 2'd0,
        MODE_FILTER  = 2'd1,
        MODE_GRID    = 2'd2,
        MODE_RECT    = 2'd3
    } mode_t;

    // register file contents plus values derived from them
    typedef struct packed {
        mode_t       mode;
        logic [23:0] match_color;
        logic [23:0] paint_color;
        logic [1:0]  filter_channel;
        logic [23:0] first_pair;
        logic [23:0] second_pair;
        logic [12:0] w_eff;
        logic [12:0] h_last;
        logic        grid_err;
        logic        rect_err;
    } cfg_t;

    // stripe phase and stripe number along one axis
    typedef struct packed {
        logic [11:0] phase;
        logic [11:0] count;
    } stripe_t;

    // position flags for the pixel under work
    typedef struct packed {
        logic last_col;
        logic last_row;
        logic on_col;
        logic on_row;
    } pos_flags_t;

    // one step along an axis: phase wraps past the thickness, count saturates
    function automatic stripe_t stripe_step(stripe_t s, logic [11:0] t);
        stripe_t     r;
        logic [12:0] p;
        p = {1'b0, s.phase} + 13'd1;
        r = s;
        if (p > {1'b0, t})
        begin
            r.phase = 12'd0;
            if (s.count != 12'hFFF)
            begin
                r.count = s.count + 12'd1;
            end
        end
        else
        begin
            r.phase = p[11:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/rpr_pix_if.sv @@
`timescale 1ns / 1ps

interface rpr_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;

    modport source (output valid, output in_blue, output in_green, output in_red,
                    input ready);
    modport sink   (input valid, input in_blue, input in_green, input in_red,
                    output ready);
endinterface

@@ rtl/rpr_res_if.sv @@
`timescale 1ns / 1ps

interface rpr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       was_changed;
    logic       setting_error;
    logic       frame_end;

    modport source (output valid, output out_blue, output out_green, output out_red,
                    output was_changed, output setting_error, output frame_end,
                    input ready);
    modport sink   (input valid, input out_blue, input out_green, input out_red,
                    input was_changed, input setting_error, input frame_end,
                    output ready);
endinterface

@@ rtl/rpr_cfg_if.sv @@
`timescale 1ns / 1ps

interface rpr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rpr_pkg::CFG_IDX_W-1:0]  index;
    logic [rpr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/rpr_cfg_regs.sv @@
`timescale 1ns / 1ps

module rpr_cfg_regs #(
    parameter int MAX_DIM = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    rpr_cfg_if.sink       regs,
    output rpr_pkg::cfg_t cfg
);
    import rpr_pkg::*;

    mode_t       mode_reg;
    logic [12:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [23:0] match_color_reg;
    logic [23:0] paint_color_reg;
    logic [1:0]  filter_channel_reg;
    logic [23:0] first_pair_reg;
    logic [23:0] second_pair_reg;
    logic [12:0] w_eff_reg;
    logic [12:0] h_last_reg;
    logic        grid_err_reg;
    logic        rect_err_reg;

    logic [12:0] w_eff_next;
    logic [12:0] h_eff;
    logic [12:0] h_last_next;
    logic        grid_err_next;
    logic        rect_err_next;
    logic [11:0] x_m1;
    logic [11:0] y_m1;
    logic [12:0] t_p1;
    logic [24:0] span_x;
    logic [24:0] span_y;
    logic        wr;

    // writes are always taken
    assign regs.ready = 1'b1;
    assign wr = regs.valid && regs.ready;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_REPLACE;
            image_width_reg    <= 13'd1;
            image_height_reg   <= 13'd1;
            match_color_reg    <= 24'd0;
            paint_color_reg    <= 24'd0;
            filter_channel_reg <= 2'd0;
            first_pair_reg     <= 24'd0;
            second_pair_reg    <= 24'd0;
        end
        else if (wr)
        begin
            case (regs.index)
                REG_MODE:           mode_reg           <= mode_t'(regs.data[1:0]);
                REG_IMAGE_WIDTH:    image_width_reg    <= regs.data[12:0];
                REG_IMAGE_HEIGHT:   image_height_reg   <= regs.data[12:0];
                REG_MATCH_COLOR:    match_color_reg    <= regs.data[23:0];
                REG_PAINT_COLOR:    paint_color_reg    <= regs.data[23:0];
                REG_FILTER_CHANNEL: filter_channel_reg <= regs.data[1:0];
                REG_FIRST_PAIR:     first_pair_reg     <= regs.data[23:0];
                REG_SECOND_PAIR:    second_pair_reg    <= regs.data[23:0];
                default:            ;
            endcase
        end
    end

    // effective image size: zero acts as one, clamp at the maximum
    always_comb
    begin
        if (image_width_reg == 13'd0)
            w_eff_next = 13'd1;
        else if (32'(image_width_reg) > MAX_DIM)
            w_eff_next = 13'(MAX_DIM);
        else
            w_eff_next = image_width_reg;

        if (image_height_reg == 13'd0)
            h_eff = 13'd1;
        else if (32'(image_height_reg) > MAX_DIM)
            h_eff = 13'(MAX_DIM);
        else
            h_eff = image_height_reg;

        h_last_next = h_eff - 13'd1;
    end

    // grid and rectangle checks
    assign x_m1   = first_pair_reg[11:0] - 12'd1;
    assign y_m1   = first_pair_reg[23:12] - 12'd1;
    assign t_p1   = {1'b0, second_pair_reg[11:0]} + 13'd1;
    assign span_x = 25'(x_m1) * 25'(t_p1);
    assign span_y = 25'(y_m1) * 25'(t_p1);

    assign grid_err_next = (first_pair_reg[11:0] <= 12'd1) ||
                           (first_pair_reg[23:12] <= 12'd1) ||
                           (second_pair_reg[11:0] == 12'd0) ||
                           (span_x >= 25'(w_eff_next)) ||
                           (span_y >= 25'(h_eff));

    assign rect_err_next = (first_pair_reg[11:0] > second_pair_reg[11:0]) ||
                           (first_pair_reg[23:12] > second_pair_reg[23:12]);

    // derived values, registered behind the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg    <= 13'd1;
            h_last_reg   <= 13'd0;
            grid_err_reg <= 1'b1;
            rect_err_reg <= 1'b0;
        end
        else
        begin
            w_eff_reg    <= w_eff_next;
            h_last_reg   <= h_last_next;
            grid_err_reg <= grid_err_next;
            rect_err_reg <= rect_err_next;
        end
    end

    always_comb
    begin
        cfg.mode           = mode_reg;
        cfg.match_color    = match_color_reg;
        cfg.paint_color    = paint_color_reg;
        cfg.filter_channel = filter_channel_reg;
        cfg.first_pair     = first_pair_reg;
        cfg.second_pair    = second_pair_reg;
        cfg.w_eff          = w_eff_reg;
        cfg.h_last         = h_last_reg;
        cfg.grid_err       = grid_err_reg;
        cfg.rect_err       = rect_err_reg;
    end

endmodule

@@ rtl/rpr_position.sv @@
`timescale 1ns / 1ps

module rpr_position #(
    parameter int MAX_DIM = 4096,
    localparam int DIM_W  = $clog2(MAX_DIM)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rpr_pkg::cfg_t       cfg,
    input  logic                advance,
    output logic [DIM_W-1:0]    column,
    output logic [DIM_W-1:0]    row,
    output rpr_pkg::pos_flags_t flags
);
    import rpr_pkg::*;

    logic [DIM_W-1:0] col_reg;
    logic [DIM_W-1:0] col_next;
    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] row_next;
    stripe_t          cs_reg;
    stripe_t          cs_next;
    stripe_t          rs_reg;
    stripe_t          rs_next;
    logic [11:0]      thick;

    assign thick = cfg.second_pair[11:0];

    // flags for the pixel at the current position
    always_comb
    begin
        flags.last_col = (32'(col_reg) + 32'd1) >= 32'(cfg.w_eff);
        flags.last_row = 32'(row_reg) >= 32'(cfg.h_last);
        flags.on_col   = (cs_reg.phase != 12'd0) &&
                         (({1'b0, cs_reg.count} + 13'd1) < {1'b0, cfg.first_pair[11:0]});
        flags.on_row   = (rs_reg.phase != 12'd0) &&
                         (({1'b0, rs_reg.count} + 13'd1) < {1'b0, cfg.first_pair[23:12]});
    end

    // raster step on every pixel transfer
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        cs_next  = cs_reg;
        rs_next  = rs_reg;
        if (advance)
        begin
            if (!flags.last_col)
            begin
                col_next = DIM_W'(32'(col_reg) + 32'd1);
                cs_next  = stripe_step(cs_reg, thick);
            end
            else
            begin
                col_next = '0;
                cs_next  = '0;
                if (flags.last_row)
                begin
                    row_next = '0;
                    rs_next  = '0;
                end
                else
                begin
                    row_next = DIM_W'(32'(row_reg) + 32'd1);
                    rs_next  = stripe_step(rs_reg, thick);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            cs_reg  <= '0;
            rs_reg  <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            cs_reg  <= cs_next;
            rs_reg  <= rs_next;
        end
    end

    assign column = col_reg;
    assign row    = row_reg;

    // end of row restarts the column and its stripes
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        advance && flags.last_col |=> (col_reg == '0) && (cs_reg == '0))
        else $error("column not restarted at end of row");

endmodule

@@ rtl/rpr_colour_path.sv @@
`timescale 1ns / 1ps

module rpr_colour_path #(
    parameter int MAX_DIM = 4096,
    localparam int DIM_W  = $clog2(MAX_DIM)
) (
    input  logic                clk,
    input  logic                rst_n,
    rpr_pix_if.sink             pixel,
    rpr_res_if.source           result,
    input  rpr_pkg::cfg_t       cfg,
    input  logic [DIM_W-1:0]    column,
    input  logic [DIM_W-1:0]    row,
    input  rpr_pkg::pos_flags_t flags,
    output logic                advance
);
    import rpr_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_b_reg;
    logic [7:0]  s1_g_reg;
    logic [7:0]  s1_r_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic [7:0]  res_b_reg;
    logic [7:0]  res_g_reg;
    logic [7:0]  res_r_reg;
    logic        res_changed_reg;
    logic        res_err_reg;
    logic        res_end_reg;

    logic        accept;
    logic [7:0]  b_next;
    logic [7:0]  g_next;
    logic [7:0]  r_next;
    logic        changed_next;
    logic        err_next;
    logic        paint;
    logic        row_beyond;
    logic [12:0] top;

    // handshake: input register and result register
    assign advance     = s1_valid_reg && (!res_valid_reg || result.ready);
    assign pixel.ready = !s1_valid_reg || advance;
    assign accept      = pixel.valid && pixel.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // incoming pixel
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_b_reg <= pixel.in_blue;
            s1_g_reg <= pixel.in_green;
            s1_r_reg <= pixel.in_red;
        end
    end

    // row counted from the top; rows past the height lie outside
    assign row_beyond = 32'(row) > 32'(cfg.h_last);
    assign top        = cfg.h_last - 13'(row);

    // recolour decision
    always_comb
    begin
        b_next       = s1_b_reg;
        g_next       = s1_g_reg;
        r_next       = s1_r_reg;
        changed_next = 1'b0;
        err_next     = 1'b0;
        paint        = 1'b0;
        case (cfg.mode)
            MODE_REPLACE:
            begin
                paint = {s1_r_reg, s1_g_reg, s1_b_reg} == cfg.match_color;
            end
            MODE_FILTER:
            begin
                case (cfg.filter_channel)
                    CH_BLUE:
                    begin
                        b_next       = cfg.paint_color[7:0];
                        changed_next = 1'b1;
                    end
                    CH_GREEN:
                    begin
                        g_next       = cfg.paint_color[15:8];
                        changed_next = 1'b1;
                    end
                    CH_RED:
                    begin
                        r_next       = cfg.paint_color[23:16];
                        changed_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            MODE_GRID:
            begin
                if (cfg.grid_err)
                    err_next = 1'b1;
                else
                    paint = flags.on_col || flags.on_row;
            end
            MODE_RECT:
            begin
                if (cfg.rect_err)
                    err_next = 1'b1;
                else
                    paint = row_beyond ||
                            (top < {1'b0, cfg.first_pair[23:12]}) ||
                            (top > {1'b0, cfg.second_pair[23:12]}) ||
                            (32'(column) < 32'(cfg.first_pair[11:0])) ||
                            (32'(column) > 32'(cfg.second_pair[11:0]));
            end
            default: ;
        endcase
        if (paint)
        begin
            b_next       = cfg.paint_color[7:0];
            g_next       = cfg.paint_color[15:8];
            r_next       = cfg.paint_color[23:16];
            changed_next = 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_b_reg       <= b_next;
            res_g_reg       <= g_next;
            res_r_reg       <= r_next;
            res_changed_reg <= changed_next;
            res_err_reg     <= err_next;
            res_end_reg     <= flags.last_col && flags.last_row;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.out_blue      = res_b_reg;
    assign result.out_green     = res_g_reg;
    assign result.out_red       = res_r_reg;
    assign result.was_changed   = res_changed_reg;
    assign result.setting_error = res_err_reg;
    assign result.frame_end     = res_end_reg;

    // a flagged setting error never repaints
    a_err_pass: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.setting_error |-> !result.was_changed)
        else $error("pixel repainted under a setting error");

    // full input register behind a stalled result blocks the input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && res_valid_reg && !result.ready |-> !pixel.ready)
        else $error("input taken while both stages are full");

    // a pixel moved on appears at the result on the next cycle
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("result lost after stage transfer");

endmodule

@@ rtl/raster_pixel_recolor_engine.sv @@
`timescale 1ns / 1ps

// Raster pixel recolour engine: takes one BGR pixel per transfer in bottom-up
// raster order, counts column and row itself and returns one recoloured pixel
// per input, with changed, setting-error and end-of-frame flags. A pixel is
// accepted whenever the input register is free or moves on; it sits in the
// input register while the decision logic works, then waits in the result
// register until the result side takes it; the sustained rate is one pixel
// per clock, limited only by the result side taking its transfers. Register
// writes are always accepted; the grid and rectangle checks and the effective
// image size are registered behind the register file.
module raster_pixel_recolor_engine #(
    parameter int MAX_DIM = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    rpr_pix_if.sink   pixel,
    rpr_res_if.source result,
    rpr_cfg_if.sink   regs
);
    import rpr_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM);

    cfg_t             cfg;
    pos_flags_t       flags;
    logic [DIM_W-1:0] column;
    logic [DIM_W-1:0] row;
    logic             advance;

    // register file
    rpr_cfg_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .regs  (regs),
        .cfg   (cfg)
    );

    // raster position and stripe counters
    rpr_position #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .column  (column),
        .row     (row),
        .flags   (flags)
    );

    // pixel pipeline
    rpr_colour_path #(
        .MAX_DIM (MAX_DIM)
    ) u_path (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pixel),
        .result  (result),
        .cfg     (cfg),
        .column  (column),
        .row     (row),
        .flags   (flags),
        .advance (advance)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import rpr_pkg::*;

    localparam int unsigned DIM_LIMIT     = 4096;
    localparam int          RANDOM_PIXELS = 750;
    localparam int          MAX_REPORTS   = 10;
    localparam int          HOLD_CYCLES   = 200;
    localparam logic [1:0]  CH_NONE       = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } bgr_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       changed;
        logic       err;
        logic       frame_end;
    } recolor_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rpr_pix_if pix ();
    rpr_res_if res ();
    rpr_cfg_if cfg_bus ();

    raster_pixel_recolor_engine #(
        .MAX_DIM (DIM_LIMIT)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix),
        .result (res),
        .regs   (cfg_bus)
    );

    // register file as the engine should hold it
    mode_t       cfg_mode    = MODE_REPLACE;
    logic [12:0] cfg_width   = 13'd1;
    logic [12:0] cfg_height  = 13'd1;
    logic [23:0] cfg_match   = 24'd0;
    logic [23:0] cfg_paint   = 24'd0;
    logic [1:0]  cfg_channel = CH_BLUE;
    logic [23:0] cfg_first   = 24'd0;
    logic [23:0] cfg_second  = 24'd0;

    // raster position and stripe counters
    int unsigned col_idx   = 0;
    int unsigned row_idx   = 0;
    int unsigned col_phase = 0;
    int unsigned col_count = 0;
    int unsigned row_phase = 0;
    int unsigned row_count = 0;

    bgr_t     pixel_q[$];
    recolor_t recolor_q[$];
    int       n_pushed    = 0;
    int       n_accepted  = 0;
    int       mismatches  = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    logic     hold_req    = 1'b0;
    logic     holding     = 1'b0;
    logic     hold_used   = 1'b0;
    int       hold_left   = 0;

    always #5 clk = ~clk;

    function automatic int unsigned clamp_dim(logic [12:0] v);
        if (v == 13'd0)
        begin
            return 1;
        end
        if (v > DIM_LIMIT)
        begin
            return DIM_LIMIT;
        end
        return 32'(v);
    endfunction

    // phase wraps past the thickness, count saturates at 12 bits
    function automatic void step_stripe(inout int unsigned phase, inout int unsigned count,
                                        input int unsigned t);
        if (phase + 1 > t)
        begin
            phase = 0;
            if (count < 12'hFFF)
            begin
                count = count + 1;
            end
        end
        else
        begin
            phase = phase + 1;
        end
    endfunction

    // recolour one pixel and move the raster position on
    function automatic recolor_t recolor_pixel(bgr_t px);
        recolor_t    o;
        int unsigned w, h, lo_a, hi_a, lo_b, hi_b;
        int          top;
        logic        paint, last_col, last_row;
        o.red       = px.red;
        o.green     = px.green;
        o.blue      = px.blue;
        o.changed   = 1'b0;
        o.err       = 1'b0;
        paint       = 1'b0;
        w    = clamp_dim(cfg_width);
        h    = clamp_dim(cfg_height);
        lo_a = 32'(cfg_first[11:0]);
        hi_a = 32'(cfg_first[23:12]);
        lo_b = 32'(cfg_second[11:0]);
        hi_b = 32'(cfg_second[23:12]);

        case (cfg_mode)
            MODE_REPLACE:
            begin
                paint = (px == cfg_match);
            end
            MODE_FILTER:
            begin
                case (cfg_channel)
                    CH_BLUE:
                    begin
                        o.blue    = cfg_paint[7:0];
                        o.changed = 1'b1;
                    end
                    CH_GREEN:
                    begin
                        o.green   = cfg_paint[15:8];
                        o.changed = 1'b1;
                    end
                    CH_RED:
                    begin
                        o.red     = cfg_paint[23:16];
                        o.changed = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            MODE_GRID:
            begin
                if (lo_a <= 1 || hi_a <= 1 || lo_b == 0 ||
                    (lo_a - 1) * (lo_b + 1) >= w || (hi_a - 1) * (lo_b + 1) >= h)
                begin
                    o.err = 1'b1;
                end
                else
                begin
                    paint = (col_phase != 0 && col_count < lo_a - 1) ||
                            (row_phase != 0 && row_count < hi_a - 1);
                end
            end
            default:
            begin
                if (lo_a > lo_b || hi_a > hi_b)
                begin
                    o.err = 1'b1;
                end
                else
                begin
                    // rows of the rectangle are counted from the top
                    top = int'(h) - 1 - int'(row_idx);
                    paint = top < int'(hi_a) || top > int'(hi_b) ||
                            col_idx < lo_a || col_idx > lo_b;
                end
            end
        endcase

        if (paint)
        begin
            o.red     = cfg_paint[23:16];
            o.green   = cfg_paint[15:8];
            o.blue    = cfg_paint[7:0];
            o.changed = 1'b1;
        end

        // advance column, then row at the end of a line
        last_col = col_idx + 1 >= w;
        last_row = row_idx + 1 >= h;
        if (!last_col)
        begin
            col_idx = col_idx + 1;
            step_stripe(col_phase, col_count, lo_b);
        end
        else
        begin
            col_idx   = 0;
            col_phase = 0;
            col_count = 0;
            if (last_row)
            begin
                row_idx   = 0;
                row_phase = 0;
                row_count = 0;
            end
            else
            begin
                row_idx = row_idx + 1;
                step_stripe(row_phase, row_count, lo_b);
            end
        end
        o.frame_end = last_col && last_row;
        return o;
    endfunction

    // pixel source: one transfer per accepted item, random gaps
    always @(posedge clk)
    begin : pixel_driver
        bgr_t nxt;
        if (rst_n && (!pix.valid || pix.ready))
        begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pixel_q.pop_front();
                pix.valid    <= 1'b1;
                pix.in_red   <= nxt.red;
                pix.in_green <= nxt.green;
                pix.in_blue  <= nxt.blue;
            end
            else
            begin
                pix.valid <= 1'b0;
            end
        end
    end

    // expected results for every accepted pixel
    always @(posedge clk)
    begin
        if (rst_n && pix.valid && pix.ready)
        begin
            recolor_q.push_back(recolor_pixel({pix.in_red, pix.in_green, pix.in_blue}));
            n_accepted <= n_accepted + 1;
        end
    end

    // result sink with random stalls, forced low during a hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            res.ready <= !holding && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long hold-off on the result side, counted here
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (holding)
            begin
                if (hold_left <= 1)
                begin
                    holding <= 1'b0;
                end
                hold_left <= hold_left - 1;
            end
            else if (hold_req && !hold_used)
            begin
                holding   <= 1'b1;
                hold_used <= 1'b1;
                hold_left <= HOLD_CYCLES;
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        recolor_t got;
        recolor_t want;
        if (rst_n && res.valid && res.ready)
        begin
            got = {res.out_red, res.out_green, res.out_blue,
                   res.was_changed, res.setting_error, res.frame_end};
            if (recolor_q.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected result rgb=%06h chg=%b err=%b end=%b",
                             $realtime, {got.red, got.green, got.blue},
                             got.changed, got.err, got.frame_end);
                end
            end
            else
            begin
                want = recolor_q.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.changed !== want.changed ||
                    got.err !== want.err || got.frame_end !== want.frame_end)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch exp rgb=%06h chg=%b err=%b end=%b",
                                 $realtime, {want.red, want.green, want.blue},
                                 want.changed, want.err, want.frame_end);
                        $display("%0t:          got rgb=%06h chg=%b err=%b end=%b",
                                 $realtime, {got.red, got.green, got.blue},
                                 got.changed, got.err, got.frame_end);
                    end
                end
            end
        end
    end

    // one register write transfer, then the bus is left idle before returning
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_MODE:           cfg_mode    = mode_t'(val[1:0]);
            REG_IMAGE_WIDTH:    cfg_width   = val[12:0];
            REG_IMAGE_HEIGHT:   cfg_height  = val[12:0];
            REG_MATCH_COLOR:    cfg_match   = val;
            REG_PAINT_COLOR:    cfg_paint   = val;
            REG_FILTER_CHANNEL: cfg_channel = val[1:0];
            REG_FIRST_PAIR:     cfg_first   = val;
            default:            cfg_second  = val;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_pixel(input logic [23:0] rgb);
        pixel_q.push_back(rgb);
        n_pushed = n_pushed + 1;
    endtask

    // pixels biased towards the match colour and the extremes
    task automatic push_random(input int count);
        int sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 30 && cfg_mode == MODE_REPLACE)
            begin
                push_pixel(cfg_match);
            end
            else if (sel < 38)
            begin
                push_pixel(24'h000000);
            end
            else if (sel < 46)
            begin
                push_pixel(24'hFFFFFF);
            end
            else
            begin
                push_pixel(24'($urandom));
            end
        end
    endtask

    // every pixel taken and every result back
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (n_accepted != n_pushed || recolor_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [12:0] random_dim();
        int sel;
        sel = $urandom_range(99);
        if (sel < 80)
        begin
            return 13'($urandom_range(1, 12));
        end
        if (sel < 85)
        begin
            return 13'd0;
        end
        if (sel < 90)
        begin
            return 13'($urandom_range(DIM_LIMIT, 8191));
        end
        return 13'($urandom_range(13, 300));
    endfunction

    // mostly valid grid and rectangle settings, some noise
    task automatic random_setup();
        mode_t       m;
        logic [12:0] w, h;
        int unsigned we, he, t, x, y, x0, x1, y0, y1, xlim, ylim;
        logic [23:0] first, second;
        m      = mode_t'($urandom_range(0, 3));
        w      = random_dim();
        h      = random_dim();
        we     = clamp_dim(w);
        he     = clamp_dim(h);
        first  = 24'($urandom);
        second = 24'($urandom);
        if (m == MODE_GRID && $urandom_range(9) != 0)
        begin
            t = $urandom_range(1, 3);
            if ((we - 1) / (t + 1) >= 1 && (he - 1) / (t + 1) >= 1)
            begin
                x = 2 + $urandom_range(0, (we - 1) / (t + 1) - 1);
                y = 2 + $urandom_range(0, (he - 1) / (t + 1) - 1);
                first  = {y[11:0], x[11:0]};
                second = {second[23:12], t[11:0]};
            end
        end
        else if (m == MODE_RECT && $urandom_range(9) != 0)
        begin
            xlim   = (we + 1 > 4095) ? 4095 : we + 1;
            ylim   = (he + 1 > 4095) ? 4095 : he + 1;
            x0     = $urandom_range(0, xlim);
            x1     = $urandom_range(x0, xlim);
            y0     = $urandom_range(0, ylim);
            y1     = $urandom_range(y0, ylim);
            first  = {y0[11:0], x0[11:0]};
            second = {y1[11:0], x1[11:0]};
        end
        write_reg(REG_MODE, 24'(m));
        write_reg(REG_IMAGE_WIDTH, 24'(w));
        write_reg(REG_IMAGE_HEIGHT, 24'(h));
        write_reg(REG_MATCH_COLOR, 24'($urandom));
        write_reg(REG_PAINT_COLOR, 24'($urandom));
        write_reg(REG_FILTER_CHANNEL, 24'($urandom_range(0, 3)));
        write_reg(REG_FIRST_PAIR, first);
        write_reg(REG_SECOND_PAIR, second);
    endtask

    initial
    begin : stimulus
        int directed_n;
        int done;
        logic [1:0] ch;
        pix.valid     = 1'b0;
        pix.in_red    = 8'd0;
        pix.in_green  = 8'd0;
        pix.in_blue   = 8'd0;
        res.ready     = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_MODE;
        cfg_bus.data  = 24'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // replace on a zero-sized image: every pixel ends a frame
        write_reg(REG_IMAGE_WIDTH, 24'd0);
        write_reg(REG_IMAGE_HEIGHT, 24'd0);
        write_reg(REG_MATCH_COLOR, 24'hFFFFFF);
        write_reg(REG_PAINT_COLOR, 24'h000000);
        write_reg(REG_MODE, 24'(MODE_REPLACE));
        push_pixel(24'hFFFFFF);
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFE);
        push_pixel(24'hFFFFFF);
        wait_idle();

        // filter on each channel and on the unused code, oversized width
        write_reg(REG_IMAGE_WIDTH, 24'd8191);
        write_reg(REG_IMAGE_HEIGHT, 24'd2);
        write_reg(REG_PAINT_COLOR, 24'h5AC33C);
        write_reg(REG_MODE, 24'(MODE_FILTER));
        for (int i = 0; i < 4; i++)
        begin
            ch = (i == 0) ? CH_BLUE : (i == 1) ? CH_GREEN : (i == 2) ? CH_RED : CH_NONE;
            write_reg(REG_FILTER_CHANNEL, 24'(ch));
            push_pixel(i[0] ? 24'hFFFFFF : 24'h000000);
            wait_idle();
        end

        // grid with settings at both extremes: error, pass through
        write_reg(REG_MODE, 24'(MODE_GRID));
        write_reg(REG_FIRST_PAIR, 24'h000000);
        write_reg(REG_SECOND_PAIR, 24'h000000);
        push_pixel(24'h123456);
        wait_idle();
        write_reg(REG_FIRST_PAIR, 24'hFFFFFF);
        write_reg(REG_SECOND_PAIR, 24'hFFFFFF);
        push_pixel(24'hFEDCBA);
        wait_idle();

        // valid 5x5 grid, then the width shrinks under the current column
        write_reg(REG_IMAGE_WIDTH, 24'd5);
        write_reg(REG_IMAGE_HEIGHT, 24'd5);
        write_reg(REG_FIRST_PAIR, {12'd2, 12'd2});
        write_reg(REG_SECOND_PAIR, {12'hFFF, 12'd1});
        push_random(6);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 24'd1);
        push_random(2);
        wait_idle();

        // rectangle: reversed corners, then rows beyond a shrunk height
        write_reg(REG_MODE, 24'(MODE_RECT));
        write_reg(REG_FIRST_PAIR, {12'd0, 12'd2});
        write_reg(REG_SECOND_PAIR, {12'd5, 12'd1});
        push_pixel(24'h00FF00);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 24'd2);
        write_reg(REG_IMAGE_HEIGHT, 24'd6);
        write_reg(REG_FIRST_PAIR, {12'd1, 12'd1});
        write_reg(REG_SECOND_PAIR, {12'd3, 12'd1});
        push_random(4);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 24'd2);
        push_random(2);
        wait_idle();
        write_reg(REG_FIRST_PAIR, 24'hFFFFFF);
        write_reg(REG_SECOND_PAIR, 24'hFFFFFF);
        push_random(1);
        wait_idle();

        // random phases: mostly receiver gaps, then mostly sender gaps, then none
        directed_n = n_pushed;
        while (n_pushed < directed_n + RANDOM_PIXELS)
        begin
            done = n_pushed - directed_n;
            if (done < RANDOM_PIXELS / 3)
            begin
                send_idle_pct = 21;
                recv_idle_pct = 58;
            end
            else if (done < 2 * RANDOM_PIXELS / 3)
            begin
                send_idle_pct = 58;
                recv_idle_pct = 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_setup();
            if (done >= 2 * RANDOM_PIXELS / 3 && !hold_req)
            begin
                // result side stops while pixels keep coming
                hold_req = 1'b1;
                push_random(60);
            end
            else
            begin
                push_random($urandom_range(1, 40));
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && recolor_q.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rpr_pkg.sv
rtl/rpr_pix_if.sv
rtl/rpr_res_if.sv
rtl/rpr_cfg_if.sv
rtl/rpr_cfg_regs.sv
rtl/rpr_position.sv
rtl/rpr_colour_path.sv
rtl/raster_pixel_recolor_engine.sv
tb/testbench.sv
